### rtl/grid_astar_path_search_core_macros.svh
// assertion macros shared by the search core
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define GASP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("grid search core: assertion failed");

// condition that must be followed by another in the next cycle
`define GASP_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("grid search core: sequence assertion failed");

`else

`define GASP_ASSERT(lbl, prop)
`define GASP_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

### rtl/gasp_pkg.sv
`default_nettype none

package gasp_pkg;

   // opcodes of a request word
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // kinds of a response word
   localparam logic [1:0] KIND_PATH  = 2'd0;
   localparam logic [1:0] KIND_FOUND = 2'd1;
   localparam logic [1:0] KIND_NOWAY = 2'd2;

   // move costs and limits
   localparam logic [3:0] COST_STRAIGHT = 4'd10;
   localparam logic [3:0] COST_DIAG     = 4'd14;
   localparam logic [5:0] MAX_STEPS     = 6'd62;

   // row and column offsets of the eight moves, two's complement
   localparam logic [3:0] DIR_DR [8] = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h1, 4'h1, 4'h1};
   localparam logic [3:0] DIR_DC [8] = '{4'h0, 4'hF, 4'h1, 4'hF, 4'h1, 4'h0, 4'hF, 4'h1};

   // straight moves beside a diagonal, and the last move
   localparam logic [2:0] DIR_UP    = 3'd0;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;
   localparam logic [2:0] DIR_DOWN  = 3'd5;
   localparam logic [2:0] DIR_LAST  = 3'd7;

   typedef struct packed {
      logic       opcode;
      logic [2:0] cell_row;
      logic [2:0] cell_col;
      logic       cell_is_wall;
      logic [2:0] start_row;
      logic [2:0] start_col;
      logic [2:0] goal_row;
      logic [2:0] goal_col;
   } req_word_type;

   typedef struct packed {
      logic [2:0] path_row;
      logic [2:0] path_col;
      logic [1:0] item_kind;
      logic       last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NBRD,
      S_DIR,
      S_UPD,
      S_SCAN,
      S_SHIFT,
      S_TRRD,
      S_TRCHK
   } state_type;

   // ten times the distance between two 3-bit coordinates
   function automatic logic [6:0] dist10(input logic [2:0] a, input logic [2:0] b);
      logic [2:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
   endfunction

endpackage

`default_nettype wire

### rtl/gasp_ram.sv
`default_nettype none

module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/grid_astar_path_search_core.sv
`default_nettype none

// Grid A* search core. A request word with start high and busy low is taken.
// A load word writes one wall bit. A search word keeps busy high until its
// last response: each expansion reads the eight neighbour wall bits, visits
// the eight moves (one extra cost-memory read for each reachable neighbour
// already listed), scans the open list through the queue and cost memories
// and closes the gap left by the chosen entry. The path walk back reads the
// parent move of a path cell, then steps back and sends the cell.
// Each response word is on rsp_word for exactly one cycle with rsp_strobe high
// and cannot be held off; path cells come from the goal back towards the start,
// then one status word with last set. The wall map reads as all open after
// reset.
module grid_astar_path_search_core #(
   parameter int GRID_ROWS = 8,
   parameter int GRID_COLS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire gasp_pkg::req_word_type req_word,
   output logic                       busy,
   output logic                       rsp_strobe,
   output gasp_pkg::rsp_word_type     rsp_word
);

   import gasp_pkg::*;

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int IDX_W = $clog2(CELLS);
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam logic [3:0] ROWS4 = 4'(GRID_ROWS);
   localparam logic [3:0] COLS4 = 4'(GRID_COLS);
   localparam logic [CNT_W-1:0] CELLS_CNT = CNT_W'(CELLS);

   function automatic logic [IDX_W-1:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
      logic [6:0] full;
      full = 7'(r) * 7'(GRID_COLS) + 7'(c);
      return full[IDX_W-1:0];
   endfunction

   function automatic logic in_grid(input logic [3:0] r, input logic [3:0] c);
      return !r[3] && (r < ROWS4) && !c[3] && (c < COLS4);
   endfunction

   // registers
   state_type        state_ff, state_in;
   logic [2:0]       cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [2:0]       start_r_ff, start_r_in, start_c_ff, start_c_in;
   logic [2:0]       goal_r_ff, goal_r_in, goal_c_ff, goal_c_in;
   logic [9:0]       g_ff, g_in;
   logic [3:0]       nb_cnt_ff, nb_cnt_in;
   logic [2:0]       dir_ff, dir_in;
   logic [7:0]       open_ff, open_in;
   logic [CNT_W-1:0] open_count_ff, open_count_in;
   logic [CELLS-1:0] listed_ff, listed_in;
   logic [CELLS-1:0] wall_vld_ff, wall_vld_in;
   logic             wall_vld_q_ff, wall_vld_q_in;
   logic [CNT_W-1:0] scan_i_ff, scan_i_in;
   logic             s1_vld_ff, s1_vld_in;
   logic [CNT_W-1:0] s1_pos_ff, s1_pos_in;
   logic             s2_vld_ff, s2_vld_in;
   logic [CNT_W-1:0] s2_pos_ff, s2_pos_in;
   logic [5:0]       s2_rc_ff, s2_rc_in;
   logic [11:0]      best_ff, best_in;
   logic [CNT_W-1:0] sel_ff, sel_in;
   logic [5:0]       sel_rc_ff, sel_rc_in;
   logic [9:0]       sel_g_ff, sel_g_in;
   logic [5:0]       steps_ff, steps_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   // memory ports
   logic             wall_wr_en, wall_rd_data, wall_wr_data;
   logic [IDX_W-1:0] wall_wr_addr, wall_rd_addr;
   logic             cost_wr_en;
   logic [IDX_W-1:0] cost_wr_addr, cost_rd_addr;
   logic [12:0]      cost_wr_data, cost_rd_data;
   logic             queue_wr_en;
   logic [IDX_W-1:0] queue_wr_addr, queue_rd_addr;
   logic [5:0]       queue_wr_data, queue_rd_data;

   // neighbour and move helpers
   logic [2:0]  cap_k, dd, orow, ocol;
   logic [3:0]  rd_r4, rd_c4, cap_r4, cap_c4, nr4, nc4, pr4, pc4;
   logic        diag, walk, advance_last;
   logic [10:0] ng;
   logic [IDX_W-1:0] n_idx;
   logic [11:0] f_val;

   gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
      .clock  (clock),
      .wr_en  (wall_wr_en),
      .wr_addr(wall_wr_addr),
      .wr_data(wall_wr_data),
      .rd_addr(wall_rd_addr),
      .rd_data(wall_rd_data)
   );

   gasp_ram #(.WIDTH(13), .DEPTH(CELLS)) u_cost_ram (
      .clock  (clock),
      .wr_en  (cost_wr_en),
      .wr_addr(cost_wr_addr),
      .wr_data(cost_wr_data),
      .rd_addr(cost_rd_addr),
      .rd_data(cost_rd_data)
   );

   gasp_ram #(.WIDTH(6), .DEPTH(CELLS)) u_queue_ram (
      .clock  (clock),
      .wr_en  (queue_wr_en),
      .wr_addr(queue_wr_addr),
      .wr_data(queue_wr_data),
      .rd_addr(queue_rd_addr),
      .rd_data(queue_rd_data)
   );

   // coordinates of the neighbours in use this cycle
   assign cap_k  = 3'(nb_cnt_ff - 4'd1);
   assign rd_r4  = {1'b0, cur_r_ff} + DIR_DR[nb_cnt_ff[2:0]];
   assign rd_c4  = {1'b0, cur_c_ff} + DIR_DC[nb_cnt_ff[2:0]];
   assign cap_r4 = {1'b0, cur_r_ff} + DIR_DR[cap_k];
   assign cap_c4 = {1'b0, cur_c_ff} + DIR_DC[cap_k];
   assign dd     = dir_ff;
   assign nr4    = {1'b0, cur_r_ff} + DIR_DR[dd];
   assign nc4    = {1'b0, cur_c_ff} + DIR_DC[dd];
   assign diag   = (DIR_DR[dd] != 4'h0) && (DIR_DC[dd] != 4'h0);
   assign orow   = DIR_DR[dd][3] ? DIR_UP : DIR_DOWN;
   assign ocol   = DIR_DC[dd][3] ? DIR_LEFT : DIR_RIGHT;
   assign walk   = open_ff[dd] && (!diag || (open_ff[orow] && open_ff[ocol]));
   assign ng     = {1'b0, g_ff} + {7'd0, (diag ? COST_DIAG : COST_STRAIGHT)};
   assign n_idx  = cell_idx(nr4[2:0], nc4[2:0]);
   assign f_val  = {2'b00, cost_rd_data[12:3]}
                 + {5'd0, dist10(goal_c_ff, s2_rc_ff[2:0])}
                 + {5'd0, dist10(goal_r_ff, s2_rc_ff[5:3])};
   assign pr4    = {1'b0, cur_r_ff} - DIR_DR[cost_rd_data[2:0]];
   assign pc4    = {1'b0, cur_c_ff} - DIR_DC[cost_rd_data[2:0]];
   assign advance_last = (dir_ff == DIR_LAST);

   // next state and memory control
   always_comb begin
      state_in      = state_ff;
      cur_r_in      = cur_r_ff;
      cur_c_in      = cur_c_ff;
      start_r_in    = start_r_ff;
      start_c_in    = start_c_ff;
      goal_r_in     = goal_r_ff;
      goal_c_in     = goal_c_ff;
      g_in          = g_ff;
      nb_cnt_in     = nb_cnt_ff;
      dir_in        = dir_ff;
      open_in       = open_ff;
      open_count_in = open_count_ff;
      listed_in     = listed_ff;
      wall_vld_in   = wall_vld_ff;
      wall_vld_q_in = wall_vld_q_ff;
      scan_i_in     = scan_i_ff;
      s1_vld_in     = 1'b0;
      s1_pos_in     = s1_pos_ff;
      s2_vld_in     = 1'b0;
      s2_pos_in     = s2_pos_ff;
      s2_rc_in      = s2_rc_ff;
      best_in       = best_ff;
      sel_in        = sel_ff;
      sel_rc_in     = sel_rc_ff;
      sel_g_in      = sel_g_ff;
      steps_in      = steps_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      wall_wr_en    = 1'b0;
      wall_wr_addr  = cell_idx(req_word.cell_row, req_word.cell_col);
      wall_wr_data  = req_word.cell_is_wall;
      wall_rd_addr  = '0;
      cost_wr_en    = 1'b0;
      cost_wr_addr  = n_idx;
      cost_wr_data  = {ng[9:0], dd};
      cost_rd_addr  = n_idx;
      queue_wr_en   = 1'b0;
      queue_wr_addr = open_count_ff[IDX_W-1:0];
      queue_wr_data = {nr4[2:0], nc4[2:0]};
      queue_rd_addr = scan_i_ff[IDX_W-1:0];

      unique case (state_ff)
         // take a word: load a wall bit or set up a search
         S_IDLE: begin
            if (start) begin
               if (req_word.opcode == OP_LOAD) begin
                  if (in_grid({1'b0, req_word.cell_row}, {1'b0, req_word.cell_col})) begin
                     wall_wr_en = 1'b1;
                     wall_vld_in[wall_wr_addr] = 1'b1;
                  end
               end else begin
                  start_r_in    = req_word.start_row;
                  start_c_in    = req_word.start_col;
                  goal_r_in     = req_word.goal_row;
                  goal_c_in     = req_word.goal_col;
                  listed_in     = '0;
                  open_count_in = '0;
                  if (!in_grid({1'b0, req_word.start_row}, {1'b0, req_word.start_col}) ||
                      !in_grid({1'b0, req_word.goal_row}, {1'b0, req_word.goal_col})) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{3'd0, 3'd0, KIND_NOWAY, 1'b1};
                  end else begin
                     cur_r_in  = req_word.start_row;
                     cur_c_in  = req_word.start_col;
                     g_in      = '0;
                     nb_cnt_in = '0;
                     state_in  = S_NBRD;
                  end
               end
            end
         end

         // read the eight neighbour wall bits, one a cycle
         S_NBRD: begin
            if (!nb_cnt_ff[3]) begin
               if (in_grid(rd_r4, rd_c4)) begin
                  wall_rd_addr = cell_idx(rd_r4[2:0], rd_c4[2:0]);
               end
               wall_vld_q_in = wall_vld_ff[wall_rd_addr];
            end
            if (nb_cnt_ff != 4'd0) begin
               open_in[cap_k] = in_grid(cap_r4, cap_c4) &&
                                !((cap_r4[2:0] == start_r_ff) && (cap_c4[2:0] == start_c_ff)) &&
                                !(wall_rd_data && wall_vld_q_ff);
            end
            if (nb_cnt_ff[3]) begin
               dir_in   = '0;
               state_in = S_DIR;
            end else begin
               nb_cnt_in = nb_cnt_ff + 4'd1;
            end
         end

         // one move: list a new cell, fetch the cost of a listed one or pass it over
         S_DIR: begin
            if (walk && listed_ff[n_idx]) begin
               state_in = S_UPD;
            end else begin
               if (walk && (open_count_ff < CELLS_CNT)) begin
                  cost_wr_en         = 1'b1;
                  queue_wr_en        = 1'b1;
                  listed_in[n_idx]   = 1'b1;
                  open_count_in      = open_count_ff + 1'b1;
               end
               if (advance_last) begin
                  state_in = S_SCAN;
               end else begin
                  dir_in = dir_ff + 3'd1;
               end
            end
         end

         // cheaper route to a listed cell
         S_UPD: begin
            if (ng < {1'b0, cost_rd_data[12:3]}) begin
               cost_wr_en = 1'b1;
            end
            if (advance_last) begin
               state_in = S_SCAN;
            end else begin
               dir_in   = dir_ff + 3'd1;
               state_in = S_DIR;
            end
         end

         // pipelined pass over the open list for the lowest f
         S_SCAN: begin
            if (scan_i_ff < open_count_ff) begin
               queue_rd_addr = scan_i_ff[IDX_W-1:0];
               s1_vld_in     = 1'b1;
               s1_pos_in     = scan_i_ff;
               scan_i_in     = scan_i_ff + 1'b1;
            end
            if (s1_vld_ff) begin
               cost_rd_addr = cell_idx(queue_rd_data[5:3], queue_rd_data[2:0]);
               s2_vld_in    = 1'b1;
               s2_pos_in    = s1_pos_ff;
               s2_rc_in     = queue_rd_data;
            end
            if (s2_vld_ff && (f_val < best_ff)) begin
               best_in   = f_val;
               sel_in    = s2_pos_ff;
               sel_rc_in = s2_rc_ff;
               sel_g_in  = cost_rd_data[12:3];
            end
            if ((scan_i_ff >= open_count_ff) && !s1_vld_ff && !s2_vld_ff) begin
               scan_i_in = sel_ff + 1'b1;
               state_in  = S_SHIFT;
            end
         end

         // close the gap left by the chosen entry
         S_SHIFT: begin
            if (scan_i_ff < open_count_ff) begin
               queue_rd_addr = scan_i_ff[IDX_W-1:0];
               s1_vld_in     = 1'b1;
               s1_pos_in     = scan_i_ff - 1'b1;
               scan_i_in     = scan_i_ff + 1'b1;
            end
            if (s1_vld_ff) begin
               queue_wr_en   = 1'b1;
               queue_wr_addr = s1_pos_ff[IDX_W-1:0];
               queue_wr_data = queue_rd_data;
            end
            if ((scan_i_ff >= open_count_ff) && !s1_vld_ff) begin
               open_count_in = open_count_ff - 1'b1;
               cur_r_in      = sel_rc_ff[5:3];
               cur_c_in      = sel_rc_ff[2:0];
               g_in          = sel_g_ff;
               if ((sel_rc_ff[5:3] == goal_r_ff) && (sel_rc_ff[2:0] == goal_c_ff)) begin
                  steps_in = '0;
                  state_in = S_TRRD;
               end else begin
                  nb_cnt_in = '0;
                  state_in  = S_NBRD;
               end
            end
         end

         // fetch the parent move of the current path cell
         S_TRRD: begin
            cost_rd_addr = cell_idx(cur_r_ff, cur_c_ff);
            state_in     = S_TRCHK;
         end

         // step back one cell and send it, or finish
         S_TRCHK: begin
            rsp_valid_in = 1'b1;
            if (!in_grid(pr4, pc4) ||
                ((pr4[2:0] == start_r_ff) && (pc4[2:0] == start_c_ff)) ||
                (steps_ff >= MAX_STEPS)) begin
               rsp_in   = '{3'd0, 3'd0, KIND_FOUND, 1'b1};
               state_in = S_IDLE;
            end else begin
               rsp_in   = '{pr4[2:0], pc4[2:0], KIND_PATH, 1'b0};
               cur_r_in = pr4[2:0];
               cur_c_in = pc4[2:0];
               steps_in = steps_ff + 6'd1;
               state_in = S_TRRD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // scan set-up and empty open list at the end of an expansion
      if ((state_in == S_SCAN) && (state_ff != S_SCAN)) begin
         if (open_count_in == '0) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{3'd0, 3'd0, KIND_NOWAY, 1'b1};
            state_in     = S_IDLE;
         end else begin
            scan_i_in = '0;
            best_in   = '1;
            sel_in    = '0;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         open_count_ff <= '0;
         listed_ff     <= '0;
         wall_vld_ff   <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_count_ff <= open_count_in;
         listed_ff     <= listed_in;
         wall_vld_ff   <= wall_vld_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // search payload
   always_ff @(posedge clock) begin
      cur_r_ff      <= cur_r_in;
      cur_c_ff      <= cur_c_in;
      start_r_ff    <= start_r_in;
      start_c_ff    <= start_c_in;
      goal_r_ff     <= goal_r_in;
      goal_c_ff     <= goal_c_in;
      g_ff          <= g_in;
      nb_cnt_ff     <= nb_cnt_in;
      dir_ff        <= dir_in;
      open_ff       <= open_in;
      wall_vld_q_ff <= wall_vld_q_in;
      scan_i_ff     <= scan_i_in;
      s1_pos_ff     <= s1_pos_in;
      s2_pos_ff     <= s2_pos_in;
      s2_rc_ff      <= s2_rc_in;
      best_ff       <= best_in;
      sel_ff        <= sel_in;
      sel_rc_ff     <= sel_rc_in;
      sel_g_ff      <= sel_g_in;
      steps_ff      <= steps_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // checks
   `include "grid_astar_path_search_core_macros.svh"

   `GASP_ASSERT(a_last_word_idle, rsp_strobe && rsp_word.last |-> !busy)
   `GASP_ASSERT(a_open_count_bound, open_count_ff <= CELLS_CNT)
   `GASP_ASSERT(a_strobe_has_cause, rsp_strobe |-> ($past(busy) || $past(start)))
   `GASP_ASSERT_NEXT(a_search_answers, start && !busy && (req_word.opcode == OP_SEARCH), busy || rsp_strobe)

endmodule

`default_nettype wire

### dv/grid_astar_path_search_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module grid_astar_path_search_core_tb;
   import gasp_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   req_word_type req_word;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   grid_astar_path_search_core dut (
      .clock(clock), .reset(reset), .start(start), .req_word(req_word),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   // model state
   logic         wall_copy [64];
   logic         listed [64];
   logic [9:0]   cost [64];
   logic [2:0]   parent [64];
   logic [5:0]   open_list [64];
   int           open_num;
   int           src_r, src_c;
   rsp_word_type path_words [$];
   int           mismatch_count;
   int           word_count;
   int           search_count;
   int           send_gap_pct;

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sign-extended move offsets
   function automatic int move_dr(input int d);
      return $signed(DIR_DR[d]);
   endfunction

   function automatic int move_dc(input int d);
      return $signed(DIR_DC[d]);
   endfunction

   function automatic bit open_cell(input int r, input int c);
      if (r < 0 || r > 7 || c < 0 || c > 7) return 0;
      if (r == src_r && c == src_c) return 0;
      return wall_copy[r * 8 + c] == 1'b0;
   endfunction

   function automatic int gap10(input int a, input int b);
      return (a > b ? a - b : b - a) * 10;
   endfunction

   function automatic rsp_word_type mk(input int r, input int c, input logic [1:0] k,
                                       input logic l);
      rsp_word_type w;
      w.path_row = r[2:0];
      w.path_col = c[2:0];
      w.item_kind = k;
      w.last = l;
      return w;
   endfunction

   // append one expected word
   task automatic expect_word(input rsp_word_type w);
      path_words = {path_words, w};
   endtask

   // neighbour relaxation of one closed cell
   task automatic relax_neighbours(input int r, input int c, input int g);
      int  nr, nc, ng, n;
      bit  diag;
      for (int d = 0; d < 8; d++) begin
         nr = r + move_dr(d);
         nc = c + move_dc(d);
         diag = (move_dr(d) != 0) && (move_dc(d) != 0);
         if (!open_cell(nr, nc)) continue;
         if (diag && !(open_cell(nr, c) && open_cell(r, nc))) continue;
         ng = g + (diag ? 14 : 10);
         n = nr * 8 + nc;
         if (!listed[n]) begin
            if (open_num >= 64) continue;
            listed[n] = 1'b1;
            cost[n] = ng[9:0];
            parent[n] = d[2:0];
            open_list[open_num] = n[5:0];
            open_num++;
         end else if (ng < int'(cost[n])) begin
            cost[n] = ng[9:0];
            parent[n] = d[2:0];
         end
      end
   endtask

   // predicted words of one request
   task automatic predict_path(input req_word_type w);
      int  gr, gc, cr, cc, g, best, sel, f, m, steps;
      bit  found;
      if (w.opcode == OP_LOAD) begin
         wall_copy[{w.cell_row, w.cell_col}] = w.cell_is_wall;
         return;
      end
      search_count++;
      src_r = w.start_row;
      src_c = w.start_col;
      gr = w.goal_row;
      gc = w.goal_col;
      for (int i = 0; i < 64; i++) listed[i] = 1'b0;
      open_num = 0;
      found = 0;
      cr = src_r;
      cc = src_c;
      g = 0;
      forever begin
         relax_neighbours(cr, cc, g);
         if (open_num == 0) break;
         best = 32'h7fffffff;
         sel = 0;
         for (int i = 0; i < open_num; i++) begin
            m = open_list[i];
            f = cost[m] + gap10(gc, m % 8) + gap10(gr, m / 8);
            if (f < best) begin
               best = f;
               sel = i;
            end
         end
         m = open_list[sel];
         for (int i = sel; i + 1 < open_num; i++) open_list[i] = open_list[i + 1];
         open_num--;
         cr = m / 8;
         cc = m % 8;
         g = cost[m];
         if (cr == gr && cc == gc) begin
            found = 1;
            break;
         end
      end
      if (!found) begin
         expect_word(mk(0, 0, KIND_NOWAY, 1'b1));
         return;
      end
      steps = 0;
      forever begin
         m = parent[cr * 8 + cc];
         cr -= move_dr(m);
         cc -= move_dc(m);
         if (cr < 0 || cr > 7 || cc < 0 || cc > 7 || (cr == src_r && cc == src_c)) break;
         if (steps >= 62) break;
         expect_word(mk(cr, cc, KIND_PATH, 1'b0));
         steps++;
      end
      expect_word(mk(0, 0, KIND_FOUND, 1'b1));
   endtask

   task automatic report_mismatch(input string what, input rsp_word_type got,
                                  input rsp_word_type want);
      mismatch_count++;
      $display("mismatch %s: got %0d,%0d kind %0d last %0d, want %0d,%0d kind %0d last %0d",
               what, got.path_row, got.path_col, got.item_kind, got.last,
               want.path_row, want.path_col, want.item_kind, want.last);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         word_count++;
         if (path_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_word, '0);
         end else begin
            want = path_words.pop_front();
            if (rsp_word.path_row !== want.path_row) report_mismatch("row", rsp_word, want);
            if (rsp_word.path_col !== want.path_col) report_mismatch("col", rsp_word, want);
            if (rsp_word.item_kind !== want.item_kind)
               report_mismatch("kind", rsp_word, want);
            if (rsp_word.last !== want.last) report_mismatch("last", rsp_word, want);
         end
      end
   end

   // one request word through the handshake
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      start <= 1'b1;
      req_word <= w;
      predict_path(w);
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
      // wait for a search to finish before the next word
      if (w.opcode == OP_SEARCH) begin
         while (busy || path_words.size() != 0) @(posedge clock);
      end
   endtask

   function automatic req_word_type load_word(input int r, input int c, input bit wl);
      req_word_type w;
      w = req_word_type'($urandom);
      w.opcode = OP_LOAD;
      w.cell_row = r[2:0];
      w.cell_col = c[2:0];
      w.cell_is_wall = wl;
      return w;
   endfunction

   function automatic req_word_type search_word(input int sr, input int sc, input int gr,
                                                input int gc);
      req_word_type w;
      w = req_word_type'($urandom);
      w.opcode = OP_SEARCH;
      w.start_row = sr[2:0];
      w.start_col = sc[2:0];
      w.goal_row = gr[2:0];
      w.goal_col = gc[2:0];
      return w;
   endfunction

   // corners, start on goal, walled goal, neighbour goal, walled start, diagonal blocks, no path
   task automatic test_directed();
      send_word(search_word(0, 0, 7, 7));
      send_word(search_word(7, 7, 0, 0));
      send_word(search_word(3, 3, 3, 3));
      send_word(search_word(2, 2, 2, 3));
      send_word(search_word(2, 2, 3, 3));
      send_word(load_word(5, 5, 1));
      send_word(search_word(0, 0, 5, 5));
      send_word(load_word(5, 5, 0));
      // wall line with a gap, forcing a detour
      for (int r = 0; r < 7; r++) send_word(load_word(r, 4, 1));
      send_word(search_word(0, 0, 0, 7));
      // diagonal squeeze past a corner
      send_word(load_word(7, 3, 1));
      send_word(search_word(6, 3, 7, 5));
      // start walled in by itself: its own wall bit is ignored
      send_word(load_word(0, 0, 1));
      send_word(search_word(0, 0, 1, 1));
      // close the gap: no path
      send_word(load_word(7, 4, 1));
      send_word(search_word(0, 0, 7, 7));
      for (int r = 0; r < 8; r++) send_word(load_word(r, 4, 0));
      send_word(load_word(7, 3, 0));
      send_word(load_word(0, 0, 0));
   endtask

   // random mazes and searches
   task automatic test_random(input int words);
      int n;
      n = 0;
      while (n < words) begin
         if ($urandom_range(9) < 6) begin
            send_word(load_word($urandom_range(7), $urandom_range(7), $urandom_range(3) == 0));
         end else begin
            send_word(search_word($urandom_range(7), $urandom_range(7), $urandom_range(7),
                                  $urandom_range(7)));
         end
         n++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      word_count = 0;
      search_count = 0;
      send_gap_pct = 0;
      for (int i = 0; i < 64; i++) wall_copy[i] = 1'b0;
      src_r = 0;
      src_c = 0;
      open_num = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_gap_pct = 13;
      test_random(33);
      send_gap_pct = 53;
      test_random(33);
      send_gap_pct = 0;
      test_random(33);
      while (path_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d searches, %0d response words checked", search_count, word_count);
      if (mismatch_count == 0 && path_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/gasp_pkg.sv
rtl/gasp_ram.sv
rtl/grid_astar_path_search_core.sv
dv/grid_astar_path_search_core_tb.sv
